[design/plac_pkg.sv]
package plac_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int ACC_BITS_DEF   = 48;

	// handshake to and from an iterative unit
	typedef struct packed {
		logic start;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[design/path_length_accumulator_top.sv]
// Running Euclidean path length of a track of (x, y) samples. The first item
// of a track (track_start high, or the first item after reset) records the
// position and gives a length of zero; each later item adds the distance to
// the previous position, rounded down, and the total saturates at all ones.
// peak_in is returned unchanged with the result. One item is worked on at a
// time; most of the work on a moving sample is done by the square root unit,
// which gives one result bit per cycle. in_ready is low while an item is in
// work and comes back as the result is registered. The result sits in an
// output register, so the next item is taken while it waits to be collected.
module path_length_accumulator_top #(
	parameter int COORD_BITS = plac_pkg::COORD_BITS_DEF,
	parameter int ACC_BITS   = plac_pkg::ACC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         track_start,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [31:0]           peak_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ACC_BITS-1:0]          path_length,
	output logic signed [31:0]           peak_out
);

	localparam int ROOT_W = COORD_BITS + 1;
	localparam int SUM_W  = ((ACC_BITS > ROOT_W) ? ACC_BITS : ROOT_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_ACC,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic                    have_last_q;
	logic                    out_valid_q;
	plac_pkg::unit_cmd_t     sq_cmd_q;
	plac_pkg::unit_cmd_t     rt_cmd_q;
	plac_pkg::unit_sts_t     sq_sts;
	plac_pkg::unit_sts_t     rt_sts;
	logic [COORD_BITS-1:0]   last_x_q;
	logic [COORD_BITS-1:0]   last_y_q;
	logic [COORD_BITS-1:0]   dx_q;
	logic [COORD_BITS-1:0]   dy_q;
	logic [31:0]             peak_q;
	logic [ACC_BITS-1:0]     travelled_q;
	logic [ACC_BITS-1:0]     path_length_q;
	logic [31:0]             peak_out_q;
	logic [COORD_BITS:0]     diff_x;
	logic [COORD_BITS:0]     diff_y;
	logic [COORD_BITS:0]     mag_x;
	logic [COORD_BITS:0]     mag_y;
	logic [2*COORD_BITS:0]   sq_sum;
	logic [ROOT_W-1:0]       root;
	logic [SUM_W-1:0]        acc_sum;
	logic [ACC_BITS-1:0]     acc_next;
	logic                    in_take;

	assign in_take = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign diff_x = {pos_x[COORD_BITS-1], pos_x} - {last_x_q[COORD_BITS-1], last_x_q};
	assign diff_y = {pos_y[COORD_BITS-1], pos_y} - {last_y_q[COORD_BITS-1], last_y_q};
	assign mag_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
	assign mag_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

	assign acc_sum  = SUM_W'(travelled_q) + SUM_W'(root);
	assign acc_next = (acc_sum[SUM_W-1:ACC_BITS] != '0) ? '1 : acc_sum[ACC_BITS-1:0];

	plac_sqsum #(
		.MAG_W(COORD_BITS)
	) u_sqsum (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (sq_cmd_q),
		.mag_a   (dx_q),
		.mag_b   (dy_q),
		.sts     (sq_sts),
		.sum     (sq_sum)
	);

	plac_sqrt #(
		.ROOT_W(ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rt_cmd_q),
		.radicand ({1'b0, sq_sum}),
		.sts      (rt_sts),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			sq_cmd_q    <= '0;
			rt_cmd_q    <= '0;
		end else begin
			sq_cmd_q <= '0;
			rt_cmd_q <= '0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						have_last_q <= 1'b1;
						if (track_start || !have_last_q) begin
							state_q <= ST_OUT;
						end else begin
							sq_cmd_q.start <= 1'b1;
							state_q        <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (sq_sts.done) begin
						rt_cmd_q.start <= 1'b1;
						state_q        <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rt_sts.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			last_x_q <= pos_x;
			last_y_q <= pos_y;
			dx_q     <= mag_x[COORD_BITS-1:0];
			dy_q     <= mag_y[COORD_BITS-1:0];
			peak_q   <= peak_in;
			if (track_start || !have_last_q) begin
				travelled_q <= '0;
			end
		end
		if (state_q == ST_ACC) begin
			travelled_q <= acc_next;
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			path_length_q <= travelled_q;
			peak_out_q    <= peak_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign path_length = path_length_q;
	assign peak_out    = peak_out_q;

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	a_sq_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_sts.done |-> state_q == ST_SQ)
		else $error("square sum finished out of sequence");

	a_rt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		rt_sts.done |-> state_q == ST_ROOT)
		else $error("root finished out of sequence");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sq_sts.busy && !rt_sts.busy)
		else $error("item taken while a unit is busy");

endmodule

[design/plac_sqsum.sv]
module plac_sqsum #(
	parameter int MAG_W = plac_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plac_pkg::unit_cmd_t   cmd,
	input  logic [MAG_W-1:0]      mag_a,
	input  logic [MAG_W-1:0]      mag_b,
	output plac_pkg::unit_sts_t   sts,
	output logic [2*MAG_W:0]      sum
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_A,
		PH_B,
		PH_ADD
	} phase_t;

	phase_t               phase_q;
	logic                 done_q;
	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     b_q;
	logic [2*MAG_W-1:0]   prod_q;
	logic [2*MAG_W:0]     sum_q;
	logic [MAG_W-1:0]     mul_op;

	// one multiplier, shared by both squares
	assign mul_op = (phase_q == PH_A) ? a_q : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (cmd.start) begin
						phase_q <= PH_A;
					end
				end
				PH_A: begin
					phase_q <= PH_B;
				end
				PH_B: begin
					phase_q <= PH_ADD;
				end
				PH_ADD: begin
					done_q  <= 1'b1;
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && cmd.start) begin
			a_q <= mag_a;
			b_q <= mag_b;
		end
		if (phase_q == PH_A || phase_q == PH_B) begin
			prod_q <= mul_op * mul_op;
		end
		if (phase_q == PH_B) begin
			sum_q <= {1'b0, prod_q};
		end else if (phase_q == PH_ADD) begin
			sum_q <= sum_q + {1'b0, prod_q};
		end
	end

	assign sts.busy = (phase_q != PH_IDLE);
	assign sts.done = done_q;
	assign sum      = sum_q;

endmodule

[design/plac_sqrt.sv]
module plac_sqrt #(
	parameter int ROOT_W = plac_pkg::COORD_BITS_DEF + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plac_pkg::unit_cmd_t   cmd,
	input  logic [2*ROOT_W-1:0]   radicand,
	output plac_pkg::unit_sts_t   sts,
	output logic [ROOT_W-1:0]     root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RAD_W-1:0]    rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    trial;
	logic                fits;

	// restoring square root, one result bit per cycle
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(ROOT_W - 1);
				end
			end else begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (cmd.start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end
		end else begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

[test/path_length_accumulator_top_test.sv]
`timescale 1ns / 1ps

module path_length_accumulator_top_test;

	localparam int CW = plac_pkg::COORD_BITS_DEF;
	localparam int AW = plac_pkg::ACC_BITS_DEF;
	localparam int ROOT_BITS = 34;
	localparam logic [AW-1:0] ACC_MAX = '1;
	localparam int COORD_MAX = (1 << (CW - 1)) - 1;
	localparam int COORD_MIN = -(1 << (CW - 1));
	localparam int NUM_ITEMS = 1100;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM = 600;
	localparam int CALM_TO = 750;

	typedef struct {
		logic                 start;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [31:0]   peak;
	} pos_item_t;

	typedef struct {
		logic [AW-1:0]      length;
		logic signed [31:0] peak;
	} path_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 track_start = 1'b0;
	logic signed [CW-1:0] pos_x = '0;
	logic signed [CW-1:0] pos_y = '0;
	logic signed [31:0]   peak_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [AW-1:0]        path_length;
	logic signed [31:0]   peak_out;

	pos_item_t    pending_samples[$];
	path_result_t expected_results[$];

	logic                 last_known = 1'b0;
	logic signed [CW-1:0] last_x = '0;
	logic signed [CW-1:0] last_y = '0;
	logic [AW-1:0]        trk_length = '0;

	logic in_fire = 1'b0;
	int   inputs_taken = 0;
	int   failures = 0;
	int   idle_cycles = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	logic hold_done = 1'b0;
	int   n_items = 0;

	path_length_accumulator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.track_start(track_start),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.peak_in(peak_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.path_length(path_length),
		.peak_out(peak_out)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [CW:0] abs_diff(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		return d[CW] ? -d : d;
	endfunction

	function automatic logic [ROOT_BITS-1:0] floor_sqrt(logic [63:0] sq);
		logic [ROOT_BITS-1:0]   root;
		logic [ROOT_BITS-1:0]   trial;
		logic [2*ROOT_BITS-1:0] prod;
		root = '0;
		for (int b = ROOT_BITS - 1; b >= 0; b--) begin
			trial = root | (ROOT_BITS'(1) << b);
			prod = {{ROOT_BITS{1'b0}}, trial} * {{ROOT_BITS{1'b0}}, trial};
			if (prod <= (2*ROOT_BITS)'(sq))
				root = trial;
		end
		return root;
	endfunction

	function automatic path_result_t advance_track(pos_item_t s);
		logic [CW:0]          ddx;
		logic [CW:0]          ddy;
		logic [63:0]          sq;
		logic [ROOT_BITS-1:0] step_len;
		path_result_t         r;
		if (s.start || !last_known) begin
			trk_length = '0;
		end else begin
			ddx = abs_diff(s.x, last_x);
			ddy = abs_diff(s.y, last_y);
			sq = 64'(ddx) * 64'(ddx) + 64'(ddy) * 64'(ddy);
			step_len = floor_sqrt(sq);
			if (AW'(step_len) > ACC_MAX - trk_length)
				trk_length = ACC_MAX;
			else
				trk_length = trk_length + AW'(step_len);
		end
		last_x = s.x;
		last_y = s.y;
		last_known = 1'b1;
		r.length = trk_length;
		r.peak = s.peak;
		return r;
	endfunction

	function automatic int pick_idle();
		int r;
		if (inputs_taken >= CALM_FROM && inputs_taken < CALM_TO)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic int clamp_coord(int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	task automatic add_sample(logic start, int x, int y, logic [31:0] peak);
		pos_item_t s;
		s.start = start;
		s.x = CW'(x);
		s.y = CW'(y);
		s.peak = peak;
		pending_samples.push_back(s);
		n_items++;
	endtask

	// driver
	always @(negedge clk) begin
		pos_item_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_samples.size() > 0) begin
			s = pending_samples.pop_front();
			in_valid <= 1'b1;
			track_start <= s.start;
			pos_x <= s.x;
			pos_y <= s.y;
			peak_in <= s.peak;
			gap_left <= pick_idle();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		int r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && inputs_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			stall_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (inputs_taken >= CALM_FROM && inputs_taken < CALM_TO) begin
			out_ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_ready <= 1'b1;
			end else if (r < 97) begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b0;
				stall_left <= $urandom_range(20, 60);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_fire <= 1'b0;
		else
			in_fire <= in_valid && in_ready;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		pos_item_t    s;
		path_result_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				s.start = track_start;
				s.x = pos_x;
				s.y = pos_y;
				s.peak = peak_in;
				expected_results.push_back(advance_track(s));
				inputs_taken <= inputs_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with none expected: path_length %0d peak_out %0d",
						path_length, peak_out);
					failures++;
				end else begin
					e = expected_results.pop_front();
					if (path_length !== e.length) begin
						$error("path_length mismatch: expected %0d, actual %0d",
							e.length, path_length);
						failures++;
					end
					if (peak_out !== e.peak) begin
						$error("peak_out mismatch: expected %0d, actual %0d", e.peak, peak_out);
						failures++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("path_length_accumulator_top test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int cx;
		int cy;
		int len;
		int mode;
		int r;
		logic st;

		// directed: first item after reset without a start flag, extremes, zero move
		add_sample(1'b0, 0, 0, 32'h0000_0000);
		add_sample(1'b0, COORD_MIN, COORD_MIN, 32'h8000_0000);
		add_sample(1'b0, COORD_MAX, COORD_MAX, 32'h7fff_ffff);
		add_sample(1'b0, COORD_MAX, COORD_MAX, 32'hffff_ffff);
		add_sample(1'b0, COORD_MIN, COORD_MAX, 32'h0000_0001);
		add_sample(1'b0, COORD_MAX, COORD_MIN, 32'h5555_5555);
		// track start in mid-track, then single-lsb and 3-4-5 steps
		add_sample(1'b1, 100, -100, 32'haaaa_aaaa);
		add_sample(1'b0, 101, -100, 32'h1234_5678);
		add_sample(1'b0, 104, -96, 32'hfedc_ba98);
		// diagonal lsb: root of two rounds down
		add_sample(1'b0, 105, -95, 32'h0001_0000);
		add_sample(1'b1, -1, -1, 32'hffff_0000);
		add_sample(1'b1, 0, 0, 32'h0000_ffff);
		add_sample(1'b0, -1, 0, 32'h7fff_0000);
		add_sample(1'b0, COORD_MIN, 0, 32'h8000_0001);
		add_sample(1'b0, COORD_MAX, 0, 32'h0);

		while (n_items < NUM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r >= 96) begin
				// noise
				add_sample(1'($urandom), int'($urandom) >>> (32 - CW),
					int'($urandom) >>> (32 - CW), $urandom);
			end else begin
				st = (r < 88);
				if ($urandom_range(0, 3) == 0) begin
					cx = int'($urandom) >>> (32 - CW);
					cy = int'($urandom) >>> (32 - CW);
				end else begin
					cx = int'($urandom_range(0, 8190)) - 4095;
					cy = int'($urandom_range(0, 8190)) - 4095;
				end
				add_sample(st, cx, cy, $urandom);
				len = $urandom_range(3, 30);
				for (int i = 0; i < len; i++) begin
					mode = $urandom_range(0, 9);
					case (mode)
						0: begin
						end
						1, 2, 3, 4, 5: begin
							cx = clamp_coord(cx + int'($urandom_range(0, 510)) - 255);
							cy = clamp_coord(cy + int'($urandom_range(0, 510)) - 255);
						end
						6, 7: begin
							cx = clamp_coord(cx + int'($urandom_range(0, 131070)) - 65535);
							cy = clamp_coord(cy + int'($urandom_range(0, 131070)) - 65535);
						end
						8: begin
							cx = clamp_coord(cx + int'($urandom_range(0, 8388606)) - 4194303);
							cy = clamp_coord(cy + int'($urandom_range(0, 8388606)) - 4194303);
						end
						default: begin
							cx = int'($urandom) >>> (32 - CW);
							cy = int'($urandom) >>> (32 - CW);
						end
					endcase
					add_sample(1'b0, cx, cy, $urandom);
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d expected result items never arrived", expected_results.size());
			failures++;
		end
		if (failures == 0)
			$display("path_length_accumulator_top test passed");
		else
			$display("path_length_accumulator_top test failed");
		$finish;
	end

endmodule

[path_length_accumulator_top.f]
design/plac_pkg.sv
design/plac_sqsum.sv
design/plac_sqrt.sv
design/path_length_accumulator_top.sv
test/path_length_accumulator_top_test.sv
